// ===== hdl/nrm_pkg.sv =====
package nrm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 38;
    localparam int DEN_W    = 38;
    localparam int STEP_W   = 5;
    localparam int MODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_MINMAX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM    = 2'd1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic [SAMPLE_W-1:0]        SAT_POS    = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]        SAT_NEG    = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_WAIT  = 4'b1000
    } seq_state_t;

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_PREP = 4'b0010,
        DV_RUN  = 4'b0100,
        DV_SAT  = 4'b1000
    } div_state_t;

    typedef struct packed {
        logic                 neg;
        logic [SAMPLE_W-1:0]  mag;
        logic [DEN_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                        dropped;
        logic signed [SAMPLE_W-1:0]  min_val;
        logic signed [SAMPLE_W-1:0]  max_val;
        logic signed [SUM_W-1:0]     sum_val;
    } stats_t;

endpackage

// ===== hdl/nrm_store.sv =====
module nrm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [31:0]          wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [31:0]          rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/nrm_stats.sv =====
module nrm_stats
    import nrm_pkg::*;
#(
    parameter int CW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd,
    input  logic                        drop,
    input  logic                        clr,
    input  logic signed [SAMPLE_W-1:0]  sample,
    output stats_t                      stats,
    output logic [CW-1:0]               count
);

    stats_t        stats_reg, stats_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        stats_next = stats_reg;
        count_next = count_reg;
        if (clr)
        begin
            stats_next.dropped = 1'b0;
            stats_next.min_val = SAMPLE_MAX;
            stats_next.max_val = SAMPLE_MIN;
            stats_next.sum_val = '0;
            count_next         = '0;
        end
        else if (upd)
        begin
            if (sample < stats_reg.min_val)
            begin
                stats_next.min_val = sample;
            end
            if (sample > stats_reg.max_val)
            begin
                stats_next.max_val = sample;
            end
            stats_next.sum_val = stats_reg.sum_val + SUM_W'(sample);
            count_next         = count_reg + CW'(1);
        end
        else if (drop)
        begin
            stats_next.dropped = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg.dropped <= 1'b0;
            stats_reg.min_val <= SAMPLE_MAX;
            stats_reg.max_val <= SAMPLE_MIN;
            stats_reg.sum_val <= '0;
            count_reg         <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
            count_reg <= count_next;
        end
    end

    assign stats = stats_reg;
    assign count = count_reg;

endmodule

// ===== hdl/nrm_div.sv =====
module nrm_div
    import nrm_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  div_req_t             req,
    output logic                 done,
    output logic [SAMPLE_W-1:0]  result
);

    localparam int NUM_W = SAMPLE_W + FRACTION_BITS + 1;
    localparam int HI_W  = NUM_W - SAMPLE_W;

    div_state_t           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 done_reg, done_next;
    div_req_t             req_reg;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [SAMPLE_W-1:0]  quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;
    logic [SAMPLE_W-1:0]  result_reg, result_next;

    logic [NUM_W-1:0]     num;
    logic [DEN_W-1:0]     num_hi;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;
    logic                 neg_eff;

    always_comb
    begin
        num     = {1'b0, req_reg.mag, {FRACTION_BITS{1'b0}}}
                + NUM_W'(req_reg.den >> 1);
        num_hi  = DEN_W'(num[NUM_W-1 -: HI_W]);
        trial   = {rem_reg, quo_reg[SAMPLE_W-1]};
        diff    = trial - {1'b0, req_reg.den};
        ge      = trial >= {1'b0, req_reg.den};
        neg_eff = req_reg.neg && (ovf_reg || (quo_reg != '0));
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        ovf_next    = ovf_reg;
        result_next = result_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (go)
                begin
                    state_next = DV_PREP;
                end
            end
            DV_PREP:
            begin
                ovf_next   = num_hi >= req_reg.den;
                rem_next   = num_hi;
                quo_next   = num[SAMPLE_W-1:0];
                step_next  = '0;
                state_next = DV_RUN;
            end
            DV_RUN:
            begin
                rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next  = {quo_reg[SAMPLE_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SAMPLE_W - 1))
                begin
                    state_next = DV_SAT;
                end
            end
            DV_SAT:
            begin
                if (neg_eff)
                begin
                    result_next = (ovf_reg || quo_reg[SAMPLE_W-1]) ? SAT_NEG : (~quo_reg + 1'b1);
                end
                else
                begin
                    result_next = (ovf_reg || quo_reg[SAMPLE_W-1]) ? SAT_POS : quo_reg;
                end
                done_next  = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && go)
        begin
            req_reg <= req;
        end
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/minmax_or_sum_normalizer.sv =====
// Loading: one sample per cycle, busy stays low until a sample with last is taken
// in min-max or sum mode. Closing sample: memory read, operand setup, 32 steps of
// the shared restoring divider, saturation and output register for each result.
// Each result strobes result_valid for one cycle; the receiver cannot stall.
// Reset (rst_n, async, active low) sets mode to min-max and clears the set
// statistics; the sample memory is not cleared and needs no clearing pass.
module minmax_or_sum_normalizer
    import nrm_pkg::*;
#(
    parameter int SET_CAPACITY  = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        last,
    input  logic                        mode_wr_en,
    input  logic [MODE_W-1:0]           mode_wr_data,
    output logic                        result_valid,
    output logic signed [SAMPLE_W-1:0]  scaled,
    output logic                        final_res,
    output logic                        overflowed
);

    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    seq_state_t           state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 result_valid_reg, result_valid_next;
    logic [SAMPLE_W-1:0]  scaled_reg;
    logic                 final_res_reg;
    logic                 overflowed_reg;

    logic                 accept;
    logic                 full;
    logic                 is_final;
    logic                 clr;
    logic                 div_go;
    logic                 div_done;
    logic [SAMPLE_W-1:0]  div_result;
    div_req_t             req;
    stats_t               stats;
    logic [CW-1:0]        count;
    logic [SAMPLE_W-1:0]  rd_data;

    logic signed [SAMPLE_W:0]  v_ext;
    logic signed [SAMPLE_W:0]  range_s;
    logic signed [SAMPLE_W:0]  diff_s;
    logic signed [SAMPLE_W:0]  v_abs;
    logic signed [SUM_W:0]     sum_ext;
    logic signed [SUM_W:0]     sum_abs;

    assign accept   = start && !busy;
    assign full     = count == CW'(SET_CAPACITY);
    assign is_final = (CW'(idx_reg) + CW'(1)) == count;
    assign div_go   = state_reg == ST_SETUP;

    always_comb
    begin
        v_ext   = {rd_data[SAMPLE_W-1], rd_data};
        range_s = {stats.max_val[SAMPLE_W-1], stats.max_val}
                - {stats.min_val[SAMPLE_W-1], stats.min_val};
        diff_s  = v_ext - {stats.min_val[SAMPLE_W-1], stats.min_val};
        v_abs   = v_ext[SAMPLE_W] ? -v_ext : v_ext;
        sum_ext = {stats.sum_val[SUM_W-1], stats.sum_val};
        sum_abs = sum_ext[SUM_W] ? -sum_ext : sum_ext;
        req.neg = 1'b0;
        req.mag = SAMPLE_W'(1);
        req.den = DEN_W'(2);
        if (mode_reg == MODE_MINMAX)
        begin
            if (range_s != '0)
            begin
                req.mag = diff_s[SAMPLE_W-1:0];
                req.den = DEN_W'(range_s[SAMPLE_W-1:0]);
            end
        end
        else
        begin
            if (stats.sum_val == '0)
            begin
                req.den = DEN_W'(count);
            end
            else
            begin
                req.neg = v_ext[SAMPLE_W] != sum_ext[SUM_W];
                req.mag = v_abs[SAMPLE_W-1:0];
                req.den = sum_abs[DEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        result_valid_next = 1'b0;
        clr               = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && last)
                begin
                    if (mode_reg == MODE_MINMAX || mode_reg == MODE_SUM)
                    begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        clr = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    result_valid_next = 1'b1;
                    if (is_final)
                    begin
                        clr        = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            mode_reg         <= MODE_MINMAX;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
            if (mode_wr_en)
            begin
                mode_reg <= mode_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && div_done)
        begin
            scaled_reg     <= div_result;
            final_res_reg  <= is_final;
            overflowed_reg <= stats.dropped;
        end
    end

    nrm_store #(
        .DEPTH (SET_CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && !full),
        .wr_addr (count[AW-1:0]),
        .wr_data (sample),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    nrm_stats #(
        .CW (CW)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (accept && !full),
        .drop   (accept && full),
        .clr    (clr),
        .sample (sample),
        .stats  (stats),
        .count  (count)
    );

    nrm_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (div_go),
        .req    (req),
        .done   (div_done),
        .result (div_result)
    );

    assign busy         = state_reg != ST_LOAD;
    assign result_valid = result_valid_reg;
    assign scaled       = scaled_reg;
    assign final_res    = final_res_reg;
    assign overflowed   = overflowed_reg;

    a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_res |-> !busy)
        else $error("final beat while still busy");

    a_valid_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(div_done))
        else $error("result beat without a finished division");

    a_busy_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && last))
        else $error("busy raised without a closing beat");

endmodule

// ===== sim/minmax_or_sum_normalizer_tb.sv =====
`timescale 1ns / 1ps

module minmax_or_sum_normalizer_tb
    import nrm_pkg::*;
();

    localparam int SET_CAPACITY   = 64;
    localparam int FRACTION_BITS  = 16;
    localparam int RANDOM_BEATS   = 110;
    localparam int QUIET_TAIL     = 30;
    localparam int IDLE_PAUSE     = 40;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

    typedef struct {
        logic signed [SAMPLE_W-1:0] scaled;
        logic                       fin;
        logic                       ovf;
    } ratio_t;

    class norm_checker;
        logic signed [SAMPLE_W-1:0] kept[SET_CAPACITY];
        int unsigned                kept_count;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        longint                     total;
        bit                         dropped;
        logic [MODE_W-1:0]          mode;
        ratio_t                     due[$];
        int                         errors;
        int                         checked;

        function new();
            mode    = MODE_MINMAX;
            errors  = 0;
            checked = 0;
            clear();
        endfunction

        function void clear();
            kept_count = 0;
            lo         = SAMPLE_MAX;
            hi         = SAMPLE_MIN;
            total      = 0;
            dropped    = 1'b0;
        endfunction

        function logic [SAMPLE_W-1:0] clamp(bit neg, longint unsigned mag);
            if (neg)
            begin
                if (mag >= 64'h8000_0000)
                    return SAT_NEG;
                return 32'(64'd0 - mag);
            end
            if (mag > 64'h7FFF_FFFF)
                return SAT_POS;
            return 32'(mag);
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s, logic l);
            longint unsigned span;
            longint unsigned offs;
            longint unsigned q;
            longint unsigned vm;
            longint unsigned sm;
            longint unsigned n;
            longint          v;
            ratio_t          r;
            if (kept_count < SET_CAPACITY)
            begin
                kept[kept_count] = s;
                kept_count++;
                if (s < lo)
                    lo = s;
                if (s > hi)
                    hi = s;
                total += longint'(s);
            end
            else
                dropped = 1'b1;
            if (!l)
                return;
            n = kept_count;
            if (mode == MODE_MINMAX || mode == MODE_SUM)
            begin
                for (int i = 0; i < kept_count; i++)
                begin
                    v = longint'(kept[i]);
                    if (mode == MODE_MINMAX)
                    begin
                        span = longint'(hi) - longint'(lo);
                        if (span == 0)
                            r.scaled = 32'd1 << (FRACTION_BITS - 1);
                        else
                        begin
                            offs = v - longint'(lo);
                            q = ((offs << FRACTION_BITS) + span / 2) / span;
                            r.scaled = clamp(1'b0, q);
                        end
                    end
                    else if (total == 0)
                    begin
                        q = ((64'd1 << FRACTION_BITS) + n / 2) / n;
                        r.scaled = clamp(1'b0, q);
                    end
                    else
                    begin
                        vm = (v < 0) ? -v : v;
                        sm = (total < 0) ? -total : total;
                        q = ((vm << FRACTION_BITS) + sm / 2) / sm;
                        r.scaled = clamp(((v < 0) != (total < 0)) && q != 0, q);
                    end
                    r.fin = (i + 1 == kept_count);
                    r.ovf = dropped;
                    due.insert(due.size(), r);
                end
            end
            clear();
        endfunction

        function void match_result(logic signed [SAMPLE_W-1:0] s, logic f, logic o);
            ratio_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d final %b ovf %b",
                         $time, s, f, o);
                return;
            end
            want = due.pop_front();
            checked++;
            if (s !== want.scaled)
            begin
                errors++;
                $display("%0t: scaled mismatch, expected %0d, actual %0d",
                         $time, want.scaled, s);
            end
            if (f !== want.fin)
            begin
                errors++;
                $display("%0t: final_res mismatch, expected %b, actual %b", $time, want.fin, f);
            end
            if (o !== want.ovf)
            begin
                errors++;
                $display("%0t: overflowed mismatch, expected %b, actual %b",
                         $time, want.ovf, o);
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       mode_wr_en;
    logic [MODE_W-1:0]          mode_wr_data;
    logic                       result_valid;
    logic signed [SAMPLE_W-1:0] scaled;
    logic                       final_res;
    logic                       overflowed;

    norm_checker scb = new();
    int          beats = 0;
    int          sets_by_mode[4] = '{0, 0, 0, 0};
    int          idle_cycles = 0;

    minmax_or_sum_normalizer #(
        .SET_CAPACITY  (SET_CAPACITY),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .last         (last),
        .mode_wr_en   (mode_wr_en),
        .mode_wr_data (mode_wr_data),
        .result_valid (result_valid),
        .scaled       (scaled),
        .final_res    (final_res),
        .overflowed   (overflowed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            scb.match_result(scaled, final_res, overflowed);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 2000)) - 1000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    return SAMPLE_MAX - int'($urandom_range(0, 1000));
                return SAMPLE_MIN + int'($urandom_range(0, 1000));
            end
        endcase
    endfunction

    // hold the beat until accepted; return at the next falling edge
    task automatic drive_beat(input logic signed [SAMPLE_W-1:0] s, input logic l,
                              input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        last   <= l;
        do
            @(posedge clk);
        while (busy);
        scb.take_sample(s, l);
        beats++;
        @(negedge clk);
    endtask

    task automatic send_set(input logic signed [SAMPLE_W-1:0] vals[$], input bit gaps);
        sets_by_mode[scb.mode]++;
        for (int i = 0; i < vals.size(); i++)
            drive_beat(vals[i], i == vals.size() - 1, gaps);
    endtask

    // drain, then let the block settle before touching the register
    task automatic write_mode(input logic [MODE_W-1:0] m);
        start <= 1'b0;
        while (scb.due.size() != 0 || busy)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
        mode_wr_en   <= 1'b1;
        mode_wr_data <= m;
        @(negedge clk);
        mode_wr_en <= 1'b0;
        scb.mode = m;
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] burst[$];
        int                         random_beats;
        int                         set_no;
        int                         size;
        bit                         gaps;

        rst_n        = 1'b0;
        start        = 1'b0;
        sample       = '0;
        last         = 1'b0;
        mode_wr_en   = 1'b0;
        mode_wr_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset mode is min-max
        burst = '{SAMPLE_MIN, SAMPLE_MAX, 0, -1, 1};
        send_set(burst, 1'b1);
        burst = '{7, 7, 7};
        send_set(burst, 1'b1);
        burst = '{5};
        send_set(burst, 1'b0);

        write_mode(MODE_SUM);
        burst = '{SAMPLE_MAX, SAMPLE_MIN};
        send_set(burst, 1'b1);
        burst = '{3, -3};
        send_set(burst, 1'b0);
        burst = '{-5, 2, 10};
        send_set(burst, 1'b1);
        burst = '{SAMPLE_MIN};
        send_set(burst, 1'b0);

        write_mode(MODE_NONE);
        burst = '{1, 2};
        send_set(burst, 1'b1);

        write_mode(MODE_MINMAX);

        random_beats = 0;
        set_no       = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            gaps = (random_beats < RANDOM_BEATS - QUIET_TAIL);
            if (set_no == 2)
            begin
                write_mode(MODE_W'($urandom_range(0, 1)));
                size = SET_CAPACITY + 1;
            end
            else
            begin
                if (gaps && $urandom_range(0, 2) == 0)
                    write_mode(MODE_W'($urandom_range(0, 2)));
                size = $urandom_range(1, 8);
            end
            burst.delete();
            repeat (size) burst.insert(burst.size(), pick_sample());
            send_set(burst, gaps);
            random_beats += size;
            set_no++;
        end

        start <= 1'b0;
        while (scb.due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d sample beats, %0d normalized results checked.",
                 beats, scb.checked);
        $display("Sets closed: %0d min-max, %0d by sum, %0d unsupported; one overfilled the store.",
                 sets_by_mode[MODE_MINMAX], sets_by_mode[MODE_SUM], sets_by_mode[MODE_NONE]);
        if (scb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/nrm_pkg.sv
hdl/nrm_store.sv
hdl/nrm_stats.sv
hdl/nrm_div.sv
hdl/minmax_or_sum_normalizer.sv
sim/minmax_or_sum_normalizer_tb.sv
